FILE: hdl/mi4c_pkg.sv
// Shared types, constants and helpers for the 4x4 cofactor inverse block.
// No dependencies; imported by mi4c_divider and matrix4_inverse_cofactor.
`timescale 1ns / 1ps
`default_nettype none
package mi4c_pkg;

   // Exact cofactor / determinant sums fit well inside 100 bits.
   localparam int ACC_W = 100;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_COF,
      ST_CWR,
      ST_DET,
      ST_DWR,
      ST_DCHK,
      ST_DRD,
      ST_DSTART,
      ST_DWAIT,
      ST_DOUT
   } state_type;

   typedef struct packed {
      logic [31:0] value;
      logic        sat;
   } div_result_type;

   // n-th index (0..2) of 0..3 with index ex left out.
   function automatic logic [1:0] skip_idx(input logic [1:0] ex, input logic [1:0] n);
      logic [1:0] r;
      r = (n < ex) ? n : n + 2'd1;
      return r;
   endfunction

   // Round to nearest, ties away from zero, dropping s bits; saturate to 64 bits.
   function automatic logic signed [63:0] round_sat64(input logic signed [ACC_W-1:0] v,
                                                      input int unsigned s);
      logic [ACC_W-1:0] mag;
      logic [ACC_W-1:0] m;
      logic             big;
      logic signed [63:0] r;
      mag = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
      m   = (mag + (ACC_W'(1) << (s - 1))) >> s;
      big = (m[ACC_W-1:63] != '0);
      if (v[ACC_W-1]) begin
         r = big ? {1'b1, 63'd0} : -$signed(m[63:0]);
      end else begin
         r = big ? {1'b0, {63{1'b1}}} : $signed(m[63:0]);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/mi4c_divider.sv
// Radix-2 restoring divider: (|cofactor| << FRAC_BITS) / |det|, rounded, clamped.
// Depends on mi4c_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mi4c_divider #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic signed [63:0]      cofactor,
   input  wire logic                    det_neg,
   input  wire logic [63:0]             dmag,
   output logic                         done,
   output mi4c_pkg::div_result_type     result
);
   import mi4c_pkg::*;

   localparam int NB    = 64 + FRAC_BITS;
   localparam int CNT_W = $clog2(NB + 1);

   logic              busy_ff, busy_in;
   logic              fin_ff, fin_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [NB-1:0]     num_ff, num_in;
   logic [NB-1:0]     quo_ff, quo_in;
   logic [63:0]       rem_ff, rem_in;
   logic              neg_ff, neg_in;
   div_result_type    res_ff, res_in;

   logic [63:0] cm;
   logic [64:0] r2;
   logic [64:0] r2_sub;
   logic        ge;
   logic        up;
   logic [NB-1:0] q;
   logic [NB-1:0] lim;
   logic        sat;
   logic [31:0] qm;

   always_comb begin
      cm     = cofactor[63] ? 64'(-cofactor) : 64'(cofactor);
      r2     = {rem_ff, num_ff[NB-1]};
      r2_sub = r2 - {1'b0, dmag};
      ge     = (r2 >= {1'b0, dmag});
      up     = (rem_ff >= (dmag - rem_ff));
      q      = quo_ff + NB'(up);
      lim    = neg_ff ? (NB'(1) << 31) : ((NB'(1) << 31) - NB'(1));
      sat    = (q > lim);
      qm     = sat ? lim[31:0] : q[31:0];

      busy_in = busy_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      neg_in  = neg_ff;
      res_in  = res_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NB);
         num_in  = NB'(cm) << FRAC_BITS;
         quo_in  = '0;
         rem_in  = '0;
         neg_in  = cofactor[63] ^ det_neg;
      end else if (busy_ff) begin
         rem_in = ge ? r2_sub[63:0] : r2[63:0];
         quo_in = {quo_ff[NB-2:0], ge};
         num_in = num_ff << 1;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end

      if (fin_ff) begin
         res_in.value = neg_ff ? (32'd0 - qm) : qm;
         res_in.sat   = sat;
         done_in      = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
      res_ff <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule
`default_nettype wire

FILE: hdl/matrix4_inverse_cofactor.sv
// 4x4 matrix inverse by adjugate, signed fixed point; top level.
// Depends on mi4c_pkg and mi4c_divider.
//
// Use: send 16 requests on req_* (element, row-major, Q format with FRAC_BITS
// fraction bits), one per cycle while req_stall is low. After the 16th the block
// raises req_stall, builds the 16 cofactors in a local memory, the determinant in
// a register, and returns 16 inverse elements on rsp_*, rsp_last on the final one.
// Per matrix the block loads the elements, works the cofactors (one shared
// multiply-accumulate fed from the element memory's single read port), then the
// determinant, then for each result runs the bit-serial divider (64 + FRAC_BITS
// iterations), one result at a time. A singular matrix returns its identity
// result without using the divider. req_stall drops as soon as the last result
// sits in the output register, so the next matrix can load while it waits.
// A receiver stall on rsp_* holds the output register and pauses the sequence.
// Reset (synchronous) empties the load counter and output register and sets the
// threshold to 1; memory contents are not cleared. Threshold register at byte
// address 0 of the csr_* APB port; write it only while idle.
`timescale 1ns / 1ps
`default_nettype none
module matrix4_inverse_cofactor #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // request channel
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [31:0] req_element,
   // result channel
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_inverse_element,
   output logic                    rsp_singular,
   output logic                    rsp_saturated,
   output logic                    rsp_last,
   // configuration
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [2:0]         csr_paddr,
   input  wire logic [31:0]        csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);
   import mi4c_pkg::*;

   localparam logic REG_SINGULAR_THRESHOLD = 1'b0;

   // ---------------- configuration ----------------
   logic [30:0] thr_ff;
   logic        csr_wr;
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite &&
                   (csr_paddr[2] == REG_SINGULAR_THRESHOLD);
   assign csr_prdata = (csr_paddr[2] == REG_SINGULAR_THRESHOLD) ? {1'b0, thr_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= 31'd1;
      end else if (csr_wr) begin
         thr_ff <= csr_pwdata[30:0];
      end
   end

   // ---------------- sequencer state ----------------
   state_type state_ff, state_in;
   logic [3:0] load_cnt_ff, load_cnt_in;
   logic [3:0] idx_ff, idx_in;       // cofactor index, det column, result index
   logic [1:0] term_ff, term_in;     // term of the 3x3 expansion
   logic [2:0] ph_ff, ph_in;         // micro step

   logic signed [31:0]      opa_ff, opa_in;
   logic signed [64:0]      sub_ff, sub_in;  // 2x2 sub-minor
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [63:0]      det_ff, det_in;
   logic [63:0]             dmag_ff, dmag_in;
   logic                    sing_ff, sing_in;

   // memories: element store and cofactor store, registered reads
   logic [31:0] mat_mem [16];
   logic [63:0] cof_mem [16];
   logic signed [31:0] rd_ff;
   logic signed [63:0] cd_ff;
   logic        mat_ren, cof_ren, cof_wen;
   logic [3:0]  mat_raddr, cof_raddr;
   logic signed [63:0] cof_wdata;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_elem_ff, rsp_elem_in;
   logic        rsp_sing_ff, rsp_sing_in;
   logic        rsp_sat_ff, rsp_sat_in;
   logic        rsp_last_ff, rsp_last_in;

   // divider
   logic           div_start;
   logic           div_done;
   div_result_type div_res;

   // datapath
   logic [1:0] row, col, r0, r1, r2, ec, sc0, sc1;
   logic signed [32:0] mul_y;
   logic signed [64:0] prod;
   logic signed [ACC_W-1:0] prod_w;
   logic signed [ACC_W-1:0] addend;
   logic       term_neg;
   logic       req_acc;
   logic       out_free;
   logic [63:0] dmag_now;

   assign req_acc  = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign prod     = opa_ff * mul_y;
   assign prod_w   = {{(ACC_W-65){prod[64]}}, prod};
   assign dmag_now = det_ff[63] ? 64'(-det_ff) : 64'(det_ff);

   always_comb begin
      row = idx_ff[3:2];
      col = idx_ff[1:0];
      r0  = skip_idx(row, 2'd0);
      r1  = skip_idx(row, 2'd1);
      r2  = skip_idx(row, 2'd2);
      ec  = skip_idx(col, term_ff);
      sc0 = skip_idx(col, (term_ff == 2'd0) ? 2'd1 : 2'd0);
      sc1 = skip_idx(col, (term_ff == 2'd2) ? 2'd1 : 2'd2);
      term_neg = (term_ff == 2'd1) ^ row[0] ^ col[0];

      state_in    = state_ff;
      load_cnt_in = load_cnt_ff;
      idx_in      = idx_ff;
      term_in     = term_ff;
      ph_in       = ph_ff;
      opa_in      = opa_ff;
      sub_in      = sub_ff;
      acc_in      = acc_ff;
      det_in      = det_ff;
      dmag_in     = dmag_ff;
      sing_in     = sing_ff;
      mat_ren     = 1'b0;
      mat_raddr   = 4'd0;
      cof_ren     = 1'b0;
      cof_raddr   = 4'd0;
      cof_wen     = 1'b0;
      cof_wdata   = round_sat64(acc_ff, 2 * FRAC_BITS);
      mul_y       = {rd_ff[31], rd_ff};
      addend      = prod_w;
      div_start   = 1'b0;
      req_stall   = 1'b1;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_elem_in  = rsp_elem_ff;
      rsp_sing_in  = rsp_sing_ff;
      rsp_sat_in   = rsp_sat_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         ST_LOAD: begin
            req_stall = 1'b0;
            if (req_valid) begin
               load_cnt_in = load_cnt_ff + 4'd1;
               if (load_cnt_ff == 4'd15) begin
                  state_in = ST_COF;
                  idx_in   = 4'd0;
                  term_in  = 2'd0;
                  ph_in    = 3'd0;
                  acc_in   = '0;
               end
            end
         end
         ST_COF: begin
            ph_in = ph_ff + 3'd1;
            case (ph_ff)
               3'd0: begin mat_ren = 1'b1; mat_raddr = {r1, sc0}; end
               3'd1: begin mat_ren = 1'b1; mat_raddr = {r2, sc1}; opa_in = rd_ff; end
               3'd2: begin mat_ren = 1'b1; mat_raddr = {r1, sc1}; sub_in = prod; end
               3'd3: begin mat_ren = 1'b1; mat_raddr = {r2, sc0}; opa_in = rd_ff; end
               3'd4: begin mat_ren = 1'b1; mat_raddr = {r0, ec}; sub_in = sub_ff - prod; end
               3'd5: begin opa_in = rd_ff; end
               3'd6: begin
                  mul_y  = sub_ff[64:32];
                  addend = prod_w <<< 32;
                  acc_in = term_neg ? acc_ff - addend : acc_ff + addend;
               end
               default: begin
                  mul_y  = {1'b0, sub_ff[31:0]};
                  acc_in = term_neg ? acc_ff - addend : acc_ff + addend;
                  ph_in  = 3'd0;
                  if (term_ff == 2'd2) begin
                     state_in = ST_CWR;
                  end else begin
                     term_in = term_ff + 2'd1;
                  end
               end
            endcase
         end
         ST_CWR: begin
            cof_wen = 1'b1;
            acc_in  = '0;
            term_in = 2'd0;
            ph_in   = 3'd0;
            idx_in  = idx_ff + 4'd1;
            state_in = (idx_ff == 4'd15) ? ST_DET : ST_COF;
         end
         ST_DET: begin
            ph_in = ph_ff + 3'd1;
            case (ph_ff)
               3'd0: begin
                  mat_ren   = 1'b1;
                  mat_raddr = {2'b00, idx_ff[1:0]};
                  cof_ren   = 1'b1;
                  cof_raddr = {2'b00, idx_ff[1:0]};
               end
               3'd1: begin opa_in = rd_ff; end
               3'd2: begin
                  mul_y  = {cd_ff[63], cd_ff[63:32]};
                  acc_in = acc_ff + (prod_w <<< 32);
               end
               default: begin
                  mul_y  = {1'b0, cd_ff[31:0]};
                  acc_in = acc_ff + addend;
                  ph_in  = 3'd0;
                  idx_in = idx_ff + 4'd1;
                  if (idx_ff[1:0] == 2'd3) begin
                     state_in = ST_DWR;
                  end
               end
            endcase
         end
         ST_DWR: begin
            det_in   = round_sat64(acc_ff, FRAC_BITS);
            state_in = ST_DCHK;
         end
         ST_DCHK: begin
            dmag_in  = dmag_now;
            sing_in  = (dmag_now < {33'd0, thr_ff}) || (dmag_now == 64'd0);
            idx_in   = 4'd0;
            state_in = ST_DRD;
         end
         ST_DRD: begin
            if (sing_ff) begin
               state_in = ST_DOUT;
            end else begin
               cof_ren   = 1'b1;
               cof_raddr = {idx_ff[1:0], idx_ff[3:2]};   // transposed
               state_in  = ST_DSTART;
            end
         end
         ST_DSTART: begin
            div_start = 1'b1;
            state_in  = ST_DWAIT;
         end
         ST_DWAIT: begin
            if (div_done) begin
               state_in = ST_DOUT;
            end
         end
         ST_DOUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_sing_in  = sing_ff;
               rsp_last_in  = (idx_ff == 4'd15);
               if (sing_ff) begin
                  rsp_elem_in = (idx_ff[3:2] == idx_ff[1:0]) ? (32'd1 << FRAC_BITS) : 32'd0;
                  rsp_sat_in  = 1'b0;
               end else begin
                  rsp_elem_in = div_res.value;
                  rsp_sat_in  = div_res.sat;
               end
               idx_in   = idx_ff + 4'd1;
               state_in = (idx_ff == 4'd15) ? ST_LOAD : ST_DRD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         load_cnt_ff  <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_cnt_ff  <= load_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      term_ff     <= term_in;
      ph_ff       <= ph_in;
      opa_ff      <= opa_in;
      sub_ff      <= sub_in;
      acc_ff      <= acc_in;
      det_ff      <= det_in;
      dmag_ff     <= dmag_in;
      sing_ff     <= sing_in;
      rsp_elem_ff <= rsp_elem_in;
      rsp_sing_ff <= rsp_sing_in;
      rsp_sat_ff  <= rsp_sat_in;
      rsp_last_ff <= rsp_last_in;
   end

   // element store: written on each accepted request
   always_ff @(posedge clock) begin
      if (req_acc) begin
         mat_mem[load_cnt_ff] <= req_element;
      end
      if (mat_ren) begin
         rd_ff <= mat_mem[mat_raddr];
      end
   end

   // cofactor store
   always_ff @(posedge clock) begin
      if (cof_wen) begin
         cof_mem[idx_ff] <= cof_wdata;
      end
      if (cof_ren) begin
         cd_ff <= cof_mem[cof_raddr];
      end
   end

   mi4c_divider #(
      .FRAC_BITS (FRAC_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .cofactor (cd_ff),
      .det_neg  (det_ff[63]),
      .dmag     (dmag_ff),
      .done     (div_done),
      .result   (div_res)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_inverse_element = rsp_elem_ff;
   assign rsp_singular        = rsp_sing_ff;
   assign rsp_saturated       = rsp_sat_ff;
   assign rsp_last            = rsp_last_ff;

endmodule
`default_nettype wire
